// ----- rtl/core/rsc_pkg.sv -----
// ----------------------------------------------------------------------------
// rsc_pkg: range sample conditioner shared definitions
// Field widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package rsc_pkg;

	// Word field widths
	localparam int CHAN_W   = 2;
	localparam int RAW_W    = 16;
	localparam int DIST_W   = 17;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam int OFFSET_W = 16;
	localparam int GAIN_W   = 17;
	localparam int WEIGHT_W = 9;
	localparam int BAND_W   = 16;
	localparam int NEED_W   = 4;
	localparam int MASK_W   = 3;

	// Reciprocal gain carries 16 fraction bits
	localparam int GAIN_FRAC = 16;

	// Defaults
	localparam int RSC_CHANNELS      = 3;
	localparam int RSC_FRACTION_BITS = 8;

	localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'd4474;
	localparam logic [GAIN_W-1:0]   GAIN_RST   = 17'd65858;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd128;
	localparam logic [BAND_W-1:0]   BAND_RST   = 16'd1280;
	localparam logic [NEED_W-1:0]   NEED_RST   = 4'd8;
	localparam logic [MASK_W-1:0]   MASK_RST   = 3'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET = 3'd0,
		REG_GAIN   = 3'd1,
		REG_WEIGHT = 3'd2,
		REG_BAND   = 3'd3,
		REG_NEED   = 3'd4,
		REG_MASK   = 3'd5
	} rsc_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAL_MUL,
		ST_OLD_MUL,
		ST_NEW_MUL,
		ST_AVG_SUM,
		ST_FINISH
	} rsc_state_t;

endpackage

// ----- rtl/core/rsc_if.sv -----
// ----------------------------------------------------------------------------
// rsc_if: channel interfaces of the range sample conditioner
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface rsc_in_if import rsc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] channel;
	logic              reading_ok;
	logic [RAW_W-1:0]  raw_distance;

	modport source (output valid, channel, reading_ok, raw_distance, input ready);
	modport sink   (input valid, channel, reading_ok, raw_distance, output ready);
endinterface

interface rsc_out_if import rsc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DIST_W-1:0] distance_out;
	logic                     distance_valid;
	logic                     channel_stable;
	logic                     all_stable;

	modport source (output valid, distance_out, distance_valid, channel_stable, all_stable,
		input ready);
	modport sink   (input valid, distance_out, distance_valid, channel_stable, all_stable,
		output ready);
endinterface

interface rsc_cfg_if import rsc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/range_sample_conditioner_top.sv -----
// ----------------------------------------------------------------------------
// range_sample_conditioner_top: per-channel distance calibration and smoothing
// Filtered words step through CAL_MUL, OLD_MUL, NEW_MUL and AVG_SUM to FINISH;
// other words go from IDLE straight to FINISH. One word is in flight at a time,
// and the single shared multiplier is used three times per filtered word.
// A waiting result does not block the next accept; a result leaves the
// sequencer only once the output register is free.
// Reset (arst_n low): registers to defaults, channel seed, count and stable state cleared.
// ----------------------------------------------------------------------------
module range_sample_conditioner_top
	import rsc_pkg::*;
#(
	parameter int CHANNELS      = RSC_CHANNELS,
	parameter int FRACTION_BITS = RSC_FRACTION_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	rsc_in_if.sink        in_ch,
	rsc_out_if.source     out_ch,
	rsc_cfg_if.sink       cfg
);

	// Fixed point sizing. Calibrated value stays below 2^(FB+17) in magnitude.
	localparam int FB      = FRACTION_BITS;
	localparam int AVG_W   = FB + 18;
	localparam int B_W     = 18;
	localparam int PROD_W  = AVG_W + B_W;
	localparam int W_W     = FB + 1;
	localparam int W_CMP   = (WEIGHT_W > W_W) ? WEIGHT_W : W_W;
	localparam int ONE     = 1 << FB;
	localparam int HALF    = 1 << (FB - 1);
	localparam int R_W     = AVG_W + 1;
	localparam int Q_W     = R_W - FB;
	localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [Q_W-1:0] POS_LIM = Q_W'(65535);
	localparam logic [Q_W-1:0] NEG_LIM = Q_W'(65536);

	// ---------------------------------------------------------------
	// Configuration registers; to be written only while idle, not enforced, always ready
	// ---------------------------------------------------------------
	logic [OFFSET_W-1:0] offset_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [BAND_W-1:0]   band_q;
	logic [NEED_W-1:0]   need_q;
	logic [MASK_W-1:0]   mask_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RST;
			gain_q   <= GAIN_RST;
			weight_q <= WEIGHT_RST;
			band_q   <= BAND_RST;
			need_q   <= NEED_RST;
			mask_q   <= MASK_RST;
		end else if (cfg.valid) begin
			case (rsc_reg_t'(cfg.index))
				REG_OFFSET: offset_q <= cfg.data[OFFSET_W-1:0];
				REG_GAIN:   gain_q   <= cfg.data[GAIN_W-1:0];
				REG_WEIGHT: weight_q <= cfg.data[WEIGHT_W-1:0];
				REG_BAND:   band_q   <= cfg.data[BAND_W-1:0];
				REG_NEED:   need_q   <= cfg.data[NEED_W-1:0];
				REG_MASK:   mask_q   <= cfg.data[MASK_W-1:0];
				default:    ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	rsc_state_t state_q, state_d;

	logic in_acc;
	logic out_free;
	logic path_filt;   // latched word takes the calibrate/average path

	logic [CHAN_W-1:0] chan_q;
	logic              ok_q;
	logic [RAW_W-1:0]  raw_q;

	logic             in_range;
	logic             filtered;
	logic [IDX_W-1:0] ch_idx;
	logic [MASK_W:0]  mask_ext;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_free = !out_ch.valid || out_ch.ready;

	// Channel decode works on the latched word
	assign in_range  = ({30'd0, chan_q} < 32'(CHANNELS));
	assign mask_ext  = {1'b0, mask_q};
	assign filtered  = mask_ext[chan_q];
	assign ch_idx    = IDX_W'(chan_q);
	assign path_filt = in_range && ok_q && filtered;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic in_filt_now;
	logic in_range_now;
	logic [MASK_W:0] in_mask_ext;

	// Path decision for the word on the port, so short words skip the multiplies
	assign in_mask_ext  = {1'b0, mask_q};
	assign in_range_now = ({30'd0, in_ch.channel} < 32'(CHANNELS));
	assign in_filt_now  = in_range_now && in_ch.reading_ok && in_mask_ext[in_ch.channel];

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = in_filt_now ? ST_CAL_MUL : ST_FINISH;
				end
			end
			ST_CAL_MUL: state_d = ST_OLD_MUL;
			ST_OLD_MUL: state_d = ST_NEW_MUL;
			ST_NEW_MUL: state_d = ST_AVG_SUM;
			ST_AVG_SUM: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Shared multiplier: (raw-offset)*gain, then (1-w)*avg, then w*cal
	// ---------------------------------------------------------------
	logic signed [AVG_W-1:0]  avg_q [CHANNELS];
	logic [CHANNELS-1:0]      seeded_q;
	logic [NEED_W-1:0]        cnt_q [CHANNELS];
	logic [CHANNELS-1:0]      stable_q;

	logic signed [AVG_W-1:0]  cal_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] acc_q;

	logic signed [AVG_W-1:0]  diff;
	logic [W_W-1:0]           w_sat;
	logic [W_W-1:0]           w_rest;
	logic signed [AVG_W-1:0]  mul_a;
	logic signed [B_W-1:0]    mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_cal_sh;
	logic signed [PROD_W-1:0] sum;
	logic signed [PROD_W-1:0] sum_sh;
	logic signed [AVG_W-1:0]  avg_new;

	// raw in fixed point minus offset, kept signed
	assign diff = (AVG_W'(raw_q) << FB) - AVG_W'(offset_q);

	// Weight saturates at one
	always_comb begin
		if (W_CMP'(weight_q) > W_CMP'(ONE)) begin
			w_sat = W_W'(ONE);
		end else begin
			w_sat = W_W'(weight_q);
		end
	end
	assign w_rest = W_W'(ONE) - w_sat;

	always_comb begin
		case (state_q)
			ST_CAL_MUL: begin
				mul_a = diff;
				mul_b = B_W'({1'b0, gain_q});
			end
			ST_OLD_MUL: begin
				mul_a = avg_q[ch_idx];
				mul_b = B_W'(w_rest);
			end
			default: begin
				mul_a = cal_q;
				mul_b = B_W'(w_sat);
			end
		endcase
	end

	assign prod        = mul_a * mul_b;
	assign prod_cal_sh = prod_q >>> GAIN_FRAC;
	assign sum         = acc_q + prod_q;
	assign sum_sh      = sum >>> FB;
	assign avg_new     = seeded_q[ch_idx] ? sum_sh[AVG_W-1:0] : cal_q;

	// ---------------------------------------------------------------
	// Stability and result formatting (filtered words read the new average)
	// ---------------------------------------------------------------
	logic signed [AVG_W:0] dev;
	logic [AVG_W:0]        dev_abs;
	logic                  band_ok;
	logic signed [R_W-1:0] rnd;
	logic [R_W-1:0]        rnd_mag;
	logic [R_W-1:0]        rnd_sh;
	logic [Q_W-1:0]        rnd_q;
	logic [DIST_W-1:0]     dist_mag;
	logic signed [DIST_W-1:0] dist_filt;
	logic signed [AVG_W-1:0]  avg_cur;

	assign avg_cur = avg_q[ch_idx];
	assign dev     = {cal_q[AVG_W-1], cal_q} - {avg_cur[AVG_W-1], avg_cur};
	assign dev_abs = dev[AVG_W] ? (AVG_W+1)'(-dev) : dev;
	assign band_ok = dev_abs < (AVG_W+1)'(band_q);

	// round half up, then truncate toward zero, saturate
	assign rnd     = {avg_cur[AVG_W-1], avg_cur} + R_W'(HALF);
	assign rnd_mag = rnd[R_W-1] ? R_W'(-rnd) : rnd;
	assign rnd_sh  = rnd_mag >> FB;
	assign rnd_q   = rnd_sh[Q_W-1:0];

	always_comb begin
		if (rnd[R_W-1]) begin
			dist_mag  = (rnd_q > NEG_LIM) ? DIST_W'(NEG_LIM) : rnd_q[DIST_W-1:0];
			dist_filt = -dist_mag;
		end else begin
			dist_mag  = (rnd_q > POS_LIM) ? DIST_W'(POS_LIM) : rnd_q[DIST_W-1:0];
			dist_filt = dist_mag;
		end
	end

	// Sample outcome of this word
	logic              sample_good;
	logic [NEED_W-1:0] cnt_cur;
	logic [NEED_W-1:0] cnt_new;
	logic              flag_new;
	logic [CHANNELS-1:0] stable_next;

	always_comb begin
		if (!ok_q) begin
			sample_good = 1'b0;
		end else if (!filtered) begin
			sample_good = (raw_q != '0);
		end else begin
			sample_good = band_ok;
		end
	end

	assign cnt_cur = cnt_q[ch_idx];

	always_comb begin
		if (!sample_good) begin
			cnt_new = '0;
		end else if (cnt_cur < need_q) begin
			cnt_new = cnt_cur + NEED_W'(1);
		end else begin
			cnt_new = cnt_cur;
		end
		flag_new = sample_good && (cnt_new >= need_q);
	end

	always_comb begin
		stable_next = stable_q;
		if (in_range) begin
			stable_next[ch_idx] = flag_new;
		end
	end

	// ---------------------------------------------------------------
	// Datapath registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			chan_q <= in_ch.channel;
			ok_q   <= in_ch.reading_ok;
			raw_q  <= in_ch.raw_distance;
		end
		case (state_q)
			ST_CAL_MUL: prod_q <= prod;
			ST_OLD_MUL: begin
				cal_q  <= prod_cal_sh[AVG_W-1:0];
				prod_q <= prod;
			end
			ST_NEW_MUL: begin
				acc_q  <= prod_q;
				prod_q <= prod;
			end
			ST_AVG_SUM: avg_q[ch_idx] <= avg_new;
			default: ;
		endcase
	end

	// Channel control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= '0;
			stable_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_AVG_SUM) begin
				seeded_q[ch_idx] <= 1'b1;
			end
			if (state_q == ST_FINISH && out_free && in_range) begin
				cnt_q[ch_idx]    <= cnt_new;
				stable_q[ch_idx] <= flag_new;
			end
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	logic                     out_valid_q;
	logic signed [DIST_W-1:0] dist_q;
	logic                     dvalid_q;
	logic                     chst_q;
	logic                     allst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			if (path_filt) begin
				dist_q <= dist_filt;
			end else if (in_range && ok_q) begin
				dist_q <= DIST_W'(raw_q);
			end else begin
				dist_q <= '0;
			end
			dvalid_q <= in_range && ok_q;
			chst_q   <= in_range && flag_new;
			allst_q  <= &stable_next;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.distance_out   = dist_q;
	assign out_ch.distance_valid = dvalid_q;
	assign out_ch.channel_stable = chst_q;
	assign out_ch.all_stable     = allst_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	// one word in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ch.ready)
		else $error("word accepted while sequencer busy");

	// a word without a reading reports no distance
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.distance_valid |-> out_ch.distance_out == '0)
		else $error("nonzero distance on invalid result");

	// failed or out of range words never leave a channel stable
	a_invalid_unstable: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.distance_valid |-> !out_ch.channel_stable)
		else $error("stable flag set on invalid result");

	// a finished word waits while the output register is held
	a_finish_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && out_ch.valid && !out_ch.ready |=> state_q == ST_FINISH)
		else $error("result dropped while output stalled");

	// the averaging multiplies only run for filtered words
	a_filt_path: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CAL_MUL |-> path_filt)
		else $error("multiply sequence started for unfiltered word");

endmodule

// ----- bench/range_sample_conditioner_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_sample_conditioner_top_tb: self-checking bench for the range conditioner
// Drives distance words with random gaps and output stalls, predicts every
// result with a local fixed-point model of calibration, averaging and the
// stability counters, and checks each result word in order.
// ----------------------------------------------------------------------------
module range_sample_conditioner_top_tb;
	import rsc_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 11;
	localparam int IDLE_PCT     = 22;    // chance per cycle that a side idles
	localparam int HOLD_CYCLES  = 300;   // long output stall
	localparam int STALL_LIMIT  = 3000;  // cycles with no handshake at all
	localparam int TAIL_CYCLES  = 12;    // extra wait after the last pending result
	localparam int PHASE_WORDS  = 180;

	localparam int     FB      = RSC_FRACTION_BITS;
	localparam longint ONE_Q   = longint'(1) << FB;
	localparam longint HALF_Q  = ONE_Q >>> 1;
	localparam longint DIST_HI = 65535;
	localparam longint DIST_LO = -65536;

	// one result word as the block should emit it
	typedef struct packed {
		logic signed [DIST_W-1:0] distance_out;
		logic                     distance_valid;
		logic                     channel_stable;
		logic                     all_stable;
	} reading_result_t;

	logic clk = 1'b0;
	logic arst_n;

	rsc_in_if  in_bus ();
	rsc_out_if out_bus ();
	rsc_cfg_if cfg_bus ();

	range_sample_conditioner_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.out_ch (out_bus),
		.cfg    (cfg_bus)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor copy of the register file
	// ------------------------------------------------------------------
	logic [OFFSET_W-1:0] cal_offset;
	logic [GAIN_W-1:0]   cal_gain;
	logic [WEIGHT_W-1:0] blend_weight;
	logic [BAND_W-1:0]   settle_band;
	logic [NEED_W-1:0]   settle_count;
	logic [MASK_W-1:0]   filter_mask;

	// Predictor copy of per-channel state
	longint                  avg_q8 [RSC_CHANNELS];   // average, 1/256 mm
	bit                      seeded [RSC_CHANNELS];
	int unsigned             good_run [RSC_CHANNELS];
	bit [RSC_CHANNELS-1:0]   stable_now;

	reading_result_t pending_results [$];

	int  mismatches = 0;
	int  stall_run  = 0;
	bit  quiet      = 1'b0;   // no idling on either side
	int  hold_asked = 0;      // bumped by a test to request a long output stall
	logic [RAW_W-1:0] near_mm [RSC_CHANNELS];   // per-channel level for steady runs

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// stability counter: good sample counts up and saturates, bad one clears
	function automatic void tally_sample(int c, bit good);
		if (!good) begin
			good_run[c]   = 0;
			stable_now[c] = 1'b0;
			return;
		end
		if (good_run[c] < settle_count)
			good_run[c]++;
		stable_now[c] = (good_run[c] >= settle_count);
	endfunction

	function automatic reading_result_t condition_reading(logic [CHAN_W-1:0] chan,
			logic ok, logic [RAW_W-1:0] raw);
		reading_result_t res;
		longint diff, cal, w, dev, r, whole_mm;
		int c;
		c        = int'(chan);
		res      = '0;
		whole_mm = 0;
		if (c < RSC_CHANNELS) begin
			if (!ok) begin
				tally_sample(c, 1'b0);
			end else if (!filter_mask[c]) begin
				// pass-through channel: raw as is, zero counts as bad
				whole_mm           = longint'(raw);
				res.distance_valid = 1'b1;
				tally_sample(c, raw != 0);
			end else begin
				w    = (blend_weight > ONE_Q) ? ONE_Q : longint'(blend_weight);
				diff = (longint'(raw) <<< FB) - longint'(cal_offset);
				cal  = (diff * longint'(cal_gain)) >>> GAIN_FRAC;   // floor
				if (!seeded[c]) begin
					avg_q8[c] = cal;
					seeded[c] = 1'b1;
				end else begin
					avg_q8[c] = ((ONE_Q - w) * avg_q8[c] + w * cal) >>> FB;
				end
				dev = cal - avg_q8[c];
				if (dev < 0)
					dev = -dev;
				tally_sample(c, dev < longint'(settle_band));
				// round half up, then truncate toward zero
				r        = avg_q8[c] + HALF_Q;
				whole_mm = (r >= 0) ? (r >>> FB) : -((-r) >>> FB);
				if (whole_mm > DIST_HI)
					whole_mm = DIST_HI;
				if (whole_mm < DIST_LO)
					whole_mm = DIST_LO;
				res.distance_valid = 1'b1;
			end
			res.channel_stable = stable_now[c];
		end
		res.distance_out = whole_mm[DIST_W-1:0];
		res.all_stable   = &stable_now;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, logic signed [31:0] got,
			logic signed [31:0] want);
		$display("ERROR @%0t: %s got %0d want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// every result word is matched against the oldest prediction
	always @(posedge clk) begin
		reading_result_t want;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word with nothing pending",
					32'(out_bus.distance_out), 0);
			end else begin
				want = pending_results.pop_front();
				if (out_bus.distance_out !== want.distance_out)
					report_mismatch("distance_out", 32'(out_bus.distance_out),
						32'(want.distance_out));
				if (out_bus.distance_valid !== want.distance_valid)
					report_mismatch("distance_valid", 32'(out_bus.distance_valid),
						32'(want.distance_valid));
				if (out_bus.channel_stable !== want.channel_stable)
					report_mismatch("channel_stable", 32'(out_bus.channel_stable),
						32'(want.channel_stable));
				if (out_bus.all_stable !== want.all_stable)
					report_mismatch("all_stable", 32'(out_bus.all_stable),
						32'(want.all_stable));
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls, quiet mode, and the long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		int hold_served;
		hold_left   = 0;
		hold_served = 0;
		out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_bus.ready <= 1'b0;
				hold_left--;
			end else if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left   = HOLD_CYCLES - 1;
				out_bus.ready <= 1'b0;
			end else if (quiet) begin
				out_bus.ready <= 1'b1;
			end else begin
				out_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any channel moving a word resets the count
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
			stall_run <= 0;
		else
			stall_run <= stall_run + 1;
	end

	initial begin : watchdog
		while (stall_run < STALL_LIMIT)
			@(posedge clk);
		$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// One input word. Valid stays high into the next call unless a gap is
	// rolled, so it is never dropped and raised in the same step.
	task automatic send_reading(int chan, logic ok, logic [RAW_W-1:0] raw);
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		in_bus.valid        <= 1'b1;
		in_bus.channel      <= CHAN_W'(chan);
		in_bus.reading_ok   <= ok;
		in_bus.raw_distance <= raw;
		do @(posedge clk); while (!in_bus.ready);
		pending_results.push_back(condition_reading(CHAN_W'(chan), ok, raw));
	endtask

	// sender pauses until every predicted word has come back
	task automatic wait_all_results();
		in_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_reg(rsc_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_OFFSET: cal_offset   = val[OFFSET_W-1:0];
			REG_GAIN:   cal_gain     = val[GAIN_W-1:0];
			REG_WEIGHT: blend_weight = val[WEIGHT_W-1:0];
			REG_BAND:   settle_band  = val[BAND_W-1:0];
			REG_NEED:   settle_count = val[NEED_W-1:0];
			REG_MASK:   filter_mask  = val[MASK_W-1:0];
			default: ;
		endcase
	endtask

	// whole register file, written only once the block has drained
	task automatic program_settings(int off, int gain, int w, int band, int need, int mask);
		wait_all_results();
		write_reg(REG_OFFSET, CFG_DATA_W'(off));
		write_reg(REG_GAIN, CFG_DATA_W'(gain));
		write_reg(REG_WEIGHT, CFG_DATA_W'(w));
		write_reg(REG_BAND, CFG_DATA_W'(band));
		write_reg(REG_NEED, CFG_DATA_W'(need));
		write_reg(REG_MASK, CFG_DATA_W'(mask));
		cfg_bus.valid <= 1'b0;
	endtask

	// mostly near-field levels, now and then anywhere in range
	function automatic logic [RAW_W-1:0] random_level();
		if ($urandom_range(9) == 0)
			return RAW_W'($urandom_range(65535));
		return RAW_W'($urandom_range(30, 3000));
	endfunction

	// Most words come in steady runs on one channel (a few mm of jitter,
	// rare failed reads) so the stability counters get a chance to fill.
	// The rest is noise over every field, channel 3 included.
	task automatic stream_readings(int count);
		int sent, run_len, c;
		logic ok;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 80) begin
				c       = $urandom_range(RSC_CHANNELS - 1);
				run_len = $urandom_range(1, 16);
				for (int k = 0; k < run_len && sent < count; k++) begin
					ok = ($urandom_range(99) >= 4);
					send_reading(c, ok, near_mm[c] + RAW_W'($urandom_range(4)));
					sent++;
				end
				if ($urandom_range(99) < 10)
					near_mm[c] = random_level();
			end else begin
				send_reading($urandom_range(3), $urandom_range(1) != 0,
					RAW_W'($urandom_range(65535)));
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset settings: negative calibration, full-scale raw, failed reads,
	// pass-through channel with zero and max raw, out-of-range channel
	task automatic test_edge_readings();
		send_reading(0, 1'b1, 16'd0);
		repeat (3) send_reading(0, 1'b1, 16'hFFFF);
		send_reading(0, 1'b0, 16'hFFFF);
		send_reading(1, 1'b1, 16'd1000);
		send_reading(2, 1'b1, 16'd0);
		send_reading(2, 1'b1, 16'hFFFF);
		send_reading(3, 1'b1, 16'hFFFF);
		send_reading(3, 1'b0, 16'd0);
		send_reading(1, 1'b0, 16'd0);
	endtask

	// over-range weight behaves as full weight; bring all channels to
	// stable, peek with an out-of-range word, then knock one down
	task automatic test_stability();
		program_settings(OFFSET_RST, GAIN_RST, 511, BAND_RST, 2, MASK_RST);
		for (int c = 0; c < RSC_CHANNELS; c++)
			repeat (2) send_reading(c, 1'b1, 16'd500);
		send_reading(3, 1'b1, 16'd12345);
		send_reading(1, 1'b0, 16'd500);
	endtask

	// zero weight freezes a seeded average; zero count makes any good
	// sample stable at once
	task automatic test_frozen_average();
		program_settings(0, 65536, 0, 65535, 0, MASK_RST);
		send_reading(0, 1'b1, 16'd700);
		send_reading(0, 1'b1, 16'd900);
		send_reading(2, 1'b1, 16'd0);
		send_reading(2, 1'b1, 16'd5);
	endtask

	// several register settings: reset values, fixed corner settings, then random ones
	task automatic test_random_settings();
		program_settings(OFFSET_RST, GAIN_RST, WEIGHT_RST, BAND_RST, NEED_RST, MASK_RST);
		stream_readings(PHASE_WORDS);
		program_settings(0, 131071, 256, 65535, 15, 7);
		stream_readings(PHASE_WORDS);
		program_settings(65535, 0, 0, 0, 1, 0);
		stream_readings(PHASE_WORDS);
		program_settings(0, 65536, 64, 2560, 4, 7);
		stream_readings(PHASE_WORDS);
		repeat (3) begin
			program_settings($urandom_range(65535), $urandom_range(131071),
				$urandom_range(511), $urandom_range(4096), $urandom_range(15),
				$urandom_range(7));
			stream_readings(PHASE_WORDS);
		end
	endtask

	// back-to-back words with neither side idling
	task automatic test_quiet_stream();
		program_settings(1000, 70000, 200, 1500, 3, 6);
		quiet = 1'b1;
		stream_readings(150);
		quiet = 1'b0;
	endtask

	// receiver holds off long enough for the block to fill and stall input
	task automatic test_output_backpressure();
		program_settings(OFFSET_RST, GAIN_RST, WEIGHT_RST, BAND_RST, NEED_RST, 7);
		hold_asked++;
		stream_readings(120);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n <= 1'b0;
		in_bus.valid        <= 1'b0;
		in_bus.channel      <= '0;
		in_bus.reading_ok   <= 1'b0;
		in_bus.raw_distance <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_OFFSET;
		cfg_bus.data  <= '0;

		// predictor starts from the reset register values and clear state
		cal_offset   = OFFSET_RST;
		cal_gain     = GAIN_RST;
		blend_weight = WEIGHT_RST;
		settle_band  = BAND_RST;
		settle_count = NEED_RST;
		filter_mask  = MASK_RST;
		stable_now   = '0;
		for (int c = 0; c < RSC_CHANNELS; c++) begin
			avg_q8[c]   = 0;
			seeded[c]   = 1'b0;
			good_run[c] = 0;
			near_mm[c]  = random_level();
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_edge_readings();
		test_stability();
		test_frozen_average();
		test_random_settings();
		test_quiet_stream();
		test_output_backpressure();

		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", pending_results.size(), 0);

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
